// ===== sv/line_segment_intersection_macros.svh =====
// Assertion macros for the segment intersection block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef LINE_SEGMENT_INTERSECTION_MACROS_SVH
`define LINE_SEGMENT_INTERSECTION_MACROS_SVH

// Same-cycle implication under reset.
`define LSI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsi assertion failed");

// Next-cycle implication under reset.
`define LSI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsi assertion failed");

`endif

// ===== sv/lsi_pkg.sv =====
// Shared types for the segment intersection block.
// No dependencies.
`timescale 1ns / 1ps
package lsi_pkg;

	// Control bits that travel with each item down the pipeline.
	typedef struct packed {
		logic vld;
		logic nz;
		logic neg_x;
		logic neg_y;
	} lsi_ctl_t;

endpackage

// ===== sv/lsi_if.sv =====
// Valid/ready channel interfaces for segment pairs and crossing results.
// No dependencies.
`timescale 1ns / 1ps
interface lsi_seg_if #(parameter int W = 16);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] first_start_x;
	logic signed [W-1:0] first_start_y;
	logic signed [W-1:0] first_end_x;
	logic signed [W-1:0] first_end_y;
	logic signed [W-1:0] second_start_x;
	logic signed [W-1:0] second_start_y;
	logic signed [W-1:0] second_end_x;
	logic signed [W-1:0] second_end_y;

	modport source(output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		second_start_x, second_start_y, second_end_x, second_end_y, input ready);
	modport sink(input valid, first_start_x, first_start_y, first_end_x, first_end_y,
		second_start_x, second_start_y, second_end_x, second_end_y, output ready);
endinterface

interface lsi_res_if #(parameter int W = 16);
	logic                valid;
	logic                ready;
	logic                hit;
	logic signed [W-1:0] cross_x;
	logic signed [W-1:0] cross_y;

	modport source(output valid, hit, cross_x, cross_y, input ready);
	modport sink(input valid, hit, cross_x, cross_y, output ready);
endinterface

// ===== sv/line_segment_intersection.sv =====
// Pipelined segment intersection by Cramer's rule with exact wide integers.
// Depends on lsi_pkg, lsi_if.sv and line_segment_intersection_macros.svh.
//
// Takes one segment pair per cycle and returns one result per pair, in order.
// Seven stages form the line coefficients, determinant and numerators, a
// restoring divider spends one stage per numerator bit, then one stage signs
// the quotient and one runs the box test into the output register. The whole
// pipeline holds while a result waits at the output.
`timescale 1ns / 1ps
`include "line_segment_intersection_macros.svh"
module line_segment_intersection #(
	parameter int COORD_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	lsi_seg_if.sink   seg,
	lsi_res_if.source res
);
	import lsi_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int AW  = CW + 1;
	localparam int MW  = 2 * CW + 1;
	localparam int BW  = 2 * CW + 2;
	localparam int CCW = 2 * CW + 2;
	localparam int DW  = 2 * CW + 3;
	localparam int LOW = CW + 1;
	localparam int HW  = CCW - LOW;
	localparam int PLW = AW + LOW + 1;
	localparam int PHW = AW + HW;
	localparam int FW  = AW + CCW;
	localparam int NW  = FW + 1;
	localparam int XW  = 8 * CW;

	logic en;
	assign en = !res.valid || res.ready;
	assign seg.ready = en;

	// stage 1: coefficients and boxes
	lsi_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, cx_s1, cy_s1;
	logic [XW-1:0] box_s1, box_s2, box_s3, box_s4, box_s5, box_s6, box_s7;

	function automatic logic [2*CW-1:0] lohi(logic signed [CW-1:0] p, logic signed [CW-1:0] q);
		return (p <= q) ? {p, q} : {q, p};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1 <= AW'(seg.first_end_y) - AW'(seg.first_start_y);
			b1_s1 <= AW'(seg.first_start_x) - AW'(seg.first_end_x);
			a2_s1 <= AW'(seg.second_end_y) - AW'(seg.second_start_y);
			b2_s1 <= AW'(seg.second_start_x) - AW'(seg.second_end_x);
			ax_s1 <= seg.first_start_x;
			ay_s1 <= seg.first_start_y;
			cx_s1 <= seg.second_start_x;
			cy_s1 <= seg.second_start_y;
			box_s1 <= {lohi(seg.first_start_x, seg.first_end_x),
				lohi(seg.first_start_y, seg.first_end_y),
				lohi(seg.second_start_x, seg.second_end_x),
				lohi(seg.second_start_y, seg.second_end_y)};
		end
	end

	// stage 2: first products
	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [MW-1:0] a1ax_s2, b1ay_s2, a2cx_s2, b2cy_s2;
	logic signed [BW-1:0] a1b2_s2, a2b1_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			a1ax_s2 <= MW'(a1_s1 * MW'(ax_s1));
			b1ay_s2 <= MW'(b1_s1 * MW'(ay_s1));
			a2cx_s2 <= MW'(a2_s1 * MW'(cx_s1));
			b2cy_s2 <= MW'(b2_s1 * MW'(cy_s1));
			a1b2_s2 <= BW'(BW'(a1_s1) * BW'(b2_s1));
			a2b1_s2 <= BW'(BW'(a2_s1) * BW'(b1_s1));
			box_s2 <= box_s1;
		end
	end

	// stage 3: line constants and determinant
	logic signed [AW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [CCW-1:0] c1_s3, c2_s3;
	logic signed [DW-1:0] det_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s3 <= a1_s2;
			b1_s3 <= b1_s2;
			a2_s3 <= a2_s2;
			b2_s3 <= b2_s2;
			c1_s3 <= CCW'(a1ax_s2) + CCW'(b1ay_s2);
			c2_s3 <= CCW'(a2cx_s2) + CCW'(b2cy_s2);
			det_s3 <= DW'(a1b2_s2) - DW'(a2b1_s2);
			box_s3 <= box_s2;
		end
	end

	// stage 4: split numerator products, determinant magnitude
	logic signed [PLW-1:0] b2c1l_s4, b1c2l_s4, a1c2l_s4, a2c1l_s4;
	logic signed [PHW-1:0] b2c1h_s4, b1c2h_s4, a1c2h_s4, a2c1h_s4;
	logic [DW-1:0] dmag_s4, dmag_s5, dmag_s6, dmag_s7;
	logic dneg_s4, dneg_s5, dneg_s6;
	logic signed [LOW:0] c1l, c2l;
	logic signed [HW-1:0] c1h, c2h;
	assign c1l = {1'b0, c1_s3[LOW-1:0]};
	assign c2l = {1'b0, c2_s3[LOW-1:0]};
	assign c1h = c1_s3[CCW-1:LOW];
	assign c2h = c2_s3[CCW-1:LOW];
	always_ff @(posedge clk) begin
		if (en) begin
			b2c1l_s4 <= PLW'(PLW'(b2_s3) * PLW'(c1l));
			b1c2l_s4 <= PLW'(PLW'(b1_s3) * PLW'(c2l));
			a1c2l_s4 <= PLW'(PLW'(a1_s3) * PLW'(c2l));
			a2c1l_s4 <= PLW'(PLW'(a2_s3) * PLW'(c1l));
			b2c1h_s4 <= PHW'(PHW'(b2_s3) * PHW'(c1h));
			b1c2h_s4 <= PHW'(PHW'(b1_s3) * PHW'(c2h));
			a1c2h_s4 <= PHW'(PHW'(a1_s3) * PHW'(c2h));
			a2c1h_s4 <= PHW'(PHW'(a2_s3) * PHW'(c1h));
			dneg_s4 <= det_s3[DW-1];
			dmag_s4 <= det_s3[DW-1] ? DW'(-det_s3) : DW'(det_s3);
			box_s4 <= box_s3;
		end
	end

	// stage 5: join partial products
	logic signed [FW-1:0] b2c1_s5, b1c2_s5, a1c2_s5, a2c1_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			b2c1_s5 <= $signed({b2c1h_s4, {LOW{1'b0}}}) + FW'(b2c1l_s4);
			b1c2_s5 <= $signed({b1c2h_s4, {LOW{1'b0}}}) + FW'(b1c2l_s4);
			a1c2_s5 <= $signed({a1c2h_s4, {LOW{1'b0}}}) + FW'(a1c2l_s4);
			a2c1_s5 <= $signed({a2c1h_s4, {LOW{1'b0}}}) + FW'(a2c1l_s4);
			dneg_s5 <= dneg_s4;
			dmag_s5 <= dmag_s4;
			box_s5 <= box_s4;
		end
	end

	// stage 6: numerators
	logic signed [NW-1:0] nx_s6, ny_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s6 <= NW'(b2c1_s5) - NW'(b1c2_s5);
			ny_s6 <= NW'(a1c2_s5) - NW'(a2c1_s5);
			dneg_s6 <= dneg_s5;
			dmag_s6 <= dmag_s5;
			box_s6 <= box_s5;
		end
	end

	// stage 7: magnitudes and quotient signs
	logic [NW-1:0] nxm_s7, nym_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			nxm_s7 <= nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
			nym_s7 <= ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);
			dmag_s7 <= dmag_s6;
			box_s7 <= box_s6;
		end
	end

	// control through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: seg.valid, nz: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{vld: ctl_s3.vld, nz: det_s3 != '0, neg_x: 1'b0, neg_y: 1'b0};
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= '{vld: ctl_s6.vld, nz: ctl_s6.nz,
				neg_x: nx_s6[NW-1] ^ dneg_s6, neg_y: ny_s6[NW-1] ^ dneg_s6};
		end
	end

	// restoring divider, one quotient bit per stage
	lsi_ctl_t      ctl_sd  [NW+1];
	logic [DW-1:0] den_sd  [NW+1];
	logic [DW-1:0] remx_sd [NW+1];
	logic [DW-1:0] remy_sd [NW+1];
	logic [NW-1:0] qx_sd   [NW+1];
	logic [NW-1:0] qy_sd   [NW+1];
	logic [XW-1:0] box_sd  [NW+1];

	assign ctl_sd[0]  = ctl_s7;
	assign den_sd[0]  = dmag_s7;
	assign remx_sd[0] = '0;
	assign remy_sd[0] = '0;
	assign qx_sd[0]   = nxm_s7;
	assign qy_sd[0]   = nym_s7;
	assign box_sd[0]  = box_s7;

	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [DW:0] tx, ty;
		logic gx, gy;
		assign tx = {remx_sd[i], qx_sd[i][NW-1]};
		assign ty = {remy_sd[i], qy_sd[i][NW-1]};
		assign gx = tx >= {1'b0, den_sd[i]};
		assign gy = ty >= {1'b0, den_sd[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sd[i+1] <= '0;
			end else if (en) begin
				ctl_sd[i+1] <= ctl_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_sd[i+1]  <= den_sd[i];
				remx_sd[i+1] <= gx ? DW'(tx - {1'b0, den_sd[i]}) : tx[DW-1:0];
				remy_sd[i+1] <= gy ? DW'(ty - {1'b0, den_sd[i]}) : ty[DW-1:0];
				qx_sd[i+1]   <= {qx_sd[i][NW-2:0], gx};
				qy_sd[i+1]   <= {qy_sd[i][NW-2:0], gy};
				box_sd[i+1]  <= box_sd[i];
			end
		end
	end

	// sign the quotients
	lsi_ctl_t ctl_sq;
	logic signed [NW-1:0] x_sq, y_sq;
	logic [XW-1:0] box_sq;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sq <= '0;
		end else if (en) begin
			ctl_sq <= ctl_sd[NW];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_sq   <= ctl_sd[NW].neg_x ? NW'(-qx_sd[NW]) : NW'(qx_sd[NW]);
			y_sq   <= ctl_sd[NW].neg_y ? NW'(-qy_sd[NW]) : NW'(qy_sd[NW]);
			box_sq <= box_sd[NW];
		end
	end

	// box test
	logic signed [CW-1:0] x1l, x1h, y1l, y1h, x2l, x2h, y2l, y2h;
	logic inbox;
	assign {x1l, x1h, y1l, y1h, x2l, x2h, y2l, y2h} = box_sq;
	assign inbox = (x_sq >= NW'(x1l)) && (x_sq <= NW'(x1h))
		&& (y_sq >= NW'(y1l)) && (y_sq <= NW'(y1h))
		&& (x_sq >= NW'(x2l)) && (x_sq <= NW'(x2h))
		&& (y_sq >= NW'(y2l)) && (y_sq <= NW'(y2h));

	logic vld_q, hit_q, nz_q;
	logic signed [CW-1:0] x_q, y_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			hit_q <= 1'b0;
			nz_q  <= 1'b0;
		end else if (en) begin
			vld_q <= ctl_sq.vld;
			hit_q <= ctl_sq.nz && inbox;
			nz_q  <= ctl_sq.nz;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= (ctl_sq.nz && inbox) ? x_sq[CW-1:0] : '0;
			y_q <= (ctl_sq.nz && inbox) ? y_sq[CW-1:0] : '0;
		end
	end

	assign res.valid   = vld_q;
	assign res.hit     = hit_q;
	assign res.cross_x = x_q;
	assign res.cross_y = y_q;

	`LSI_ASSERT_IMP(a_miss_zero, res.valid && !res.hit, res.cross_x == '0 && res.cross_y == '0)
	`LSI_ASSERT_IMP(a_parallel_miss, res.valid && !nz_q, !res.hit)
	`LSI_ASSERT_NXT(a_div_to_out, en && ctl_sq.vld, res.valid)

endmodule

// ===== tb/line_segment_intersection_tb.sv =====
// Testbench for line_segment_intersection: drives segment pairs over lsi_seg_if,
// checks hit and crossing point on lsi_res_if against an exact Cramer's-rule predictor.
// Depends on lsi_if.sv and line_segment_intersection.sv.
`timescale 1ns / 1ps

typedef struct {
	bit               hit;
	bit signed [15:0] cross_x;
	bit signed [15:0] cross_y;
} crossing_t;

class crossing_board;
	crossing_t pending[$];
	int        mismatches;
	int        checked;
	int        hits;

	function bit box_ok(logic signed [127:0] v, logic signed [127:0] p,
		logic signed [127:0] q);
		logic signed [127:0] lo;
		logic signed [127:0] hi;
		lo = (p <= q) ? p : q;
		hi = (p <= q) ? q : p;
		return (v >= lo) && (v <= hi);
	endfunction

	function void note_pair(bit signed [15:0] ax, bit signed [15:0] ay,
		bit signed [15:0] bx, bit signed [15:0] by, bit signed [15:0] cx,
		bit signed [15:0] cy, bit signed [15:0] dx, bit signed [15:0] dy);
		logic signed [127:0] a1, b1, c1, a2, b2, c2, det, x, y;
		crossing_t e;
		a1 = by - ay;
		b1 = ax - bx;
		c1 = a1 * ax + b1 * ay;
		a2 = dy - cy;
		b2 = cx - dx;
		c2 = a2 * cx + b2 * cy;
		det = a1 * b2 - a2 * b1;
		e = '{0, 0, 0};
		if (det != 0) begin
			x = (b2 * c1 - b1 * c2) / det;
			y = (a1 * c2 - a2 * c1) / det;
			if (box_ok(x, ax, bx) && box_ok(y, ay, by) && box_ok(x, cx, dx) &&
				box_ok(y, cy, dy)) begin
				e.hit = 1;
				e.cross_x = x[15:0];
				e.cross_y = y[15:0];
			end
		end
		pending.push_back(e);
	endfunction

	function void check_result(bit h, bit signed [15:0] rx, bit signed [15:0] ry);
		crossing_t e;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected transaction: hit=%0d x=%0d y=%0d", h, rx, ry);
			return;
		end
		e = pending.pop_front();
		hits += h;
		if (e.hit !== h || e.cross_x !== rx || e.cross_y !== ry) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
					e.hit, e.cross_x, e.cross_y, h, rx, ry);
		end
	endfunction
endclass

module line_segment_intersection_tb;
	logic clk;
	logic arst_n;
	int   cycles;
	bit   calm;
	int   sent;

	lsi_seg_if #(16) seg();
	lsi_res_if #(16) res();
	crossing_board board;

	line_segment_intersection #(.COORD_WIDTH(16)) dut (
		.clk(clk), .arst_n(arst_n), .seg(seg.sink), .res(res.source)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("timeout");
				$display("line_segment_intersection_tb: done, errors");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_result(res.hit, res.cross_x, res.cross_y);
	end

	initial begin
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				res.ready <= 0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			res.ready <= 1;
		end
	end

	task automatic send_pair(bit signed [15:0] ax, bit signed [15:0] ay,
		bit signed [15:0] bx, bit signed [15:0] by, bit signed [15:0] cx,
		bit signed [15:0] cy, bit signed [15:0] dx, bit signed [15:0] dy);
		if (!calm && $urandom_range(0, 7) == 0) begin
			seg.valid <= 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		seg.valid <= 1;
		seg.first_start_x <= ax;
		seg.first_start_y <= ay;
		seg.first_end_x <= bx;
		seg.first_end_y <= by;
		seg.second_start_x <= cx;
		seg.second_start_y <= cy;
		seg.second_end_x <= dx;
		seg.second_end_y <= dy;
		do @(posedge clk); while (!seg.ready);
		board.note_pair(ax, ay, bx, by, cx, cy, dx, dy);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random(int span);
		bit signed [15:0] p[8];
		bit signed [15:0] cx, cy;
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			// crossing near a shared point, short arms
			cx = 16'($urandom);
			cy = 16'($urandom);
			foreach (p[i])
				p[i] = (i % 2 ? cy : cx) + $signed(16'($urandom_range(0, 2 * span))) -
					16'(span);
		end else if (r < 8) begin
			foreach (p[i])
				p[i] = 16'($urandom);
		end else begin
			// parallel pair: second segment is the first shifted
			foreach (p[i])
				p[i] = 16'($urandom_range(0, 1023)) - 16'(512);
			cx = 16'($urandom_range(0, 255));
			cy = 16'($urandom_range(0, 255));
			p[4] = p[0] + cx;
			p[5] = p[1] + cy;
			p[6] = p[2] + cx;
			p[7] = p[3] + cy;
		end
		send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
	endtask

	initial begin
		board = new();
		calm = 0;
		sent = 0;
		arst_n = 0;
		seg.valid = 0;
		seg.first_start_x = 0;
		seg.first_start_y = 0;
		seg.first_end_x = 0;
		seg.first_end_y = 0;
		seg.second_start_x = 0;
		seg.second_start_y = 0;
		seg.second_end_x = 0;
		seg.second_end_y = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_pair(-256, 0, 256, 0, 0, -256, 0, 256);
		send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_pair(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
		send_pair(0, 0, 256, 256, 0, 256, 256, 512);
		send_pair(0, 0, 512, 512, 256, 256, 768, 768);
		send_pair(100, 100, 100, 100, 0, 0, 512, 512);
		send_pair(5, 5, 5, 5, 5, 5, 5, 5);
		send_pair(0, 0, 256, 0, 512, -256, 512, 256);
		send_pair(0, 0, 256, 0, 256, -256, 256, 256);
		send_pair(0, 0, 1, 3, 0, 1, 3, 0);
		send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
		send_pair(32767, 32767, 32767, -32768, -32768, 32767, 32767, 32767);
		send_pair(-32768, -32768, -32768, 32767, -32768, -32768, 32767, -32768);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
		send_pair(0, 0, 3, 1, 0, 1, 3, 0);

		for (int i = 0; i < 800; i++)
			send_random(i % 50 == 0 ? 32767 : 64);
		seg.valid <= 0;
		while (board.pending.size() != 0)
			@(negedge clk);
		for (int i = 0; i < 900; i++)
			send_random(i % 50 == 0 ? 32767 : 300);
		calm = 1;
		for (int i = 0; i < 250; i++)
			send_random(128);
		seg.valid <= 0;

		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		$display("covered %0d segment pairs, %0d results checked, %0d hits",
			sent, board.checked, board.hits);
		$display("directed extremes, parallel and degenerate pairs, random crossings");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("line_segment_intersection_tb: done, clean");
		else
			$display("line_segment_intersection_tb: done, errors");
		$finish;
	end
endmodule

// ===== line_segment_intersection.f =====
+incdir+sv
sv/lsi_pkg.sv
sv/lsi_if.sv
sv/line_segment_intersection.sv
tb/line_segment_intersection_tb.sv
